// ===== rtl/dqs_pkg.sv =====
package dqs_pkg;

  // Action codes of an input word.
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_ADD      = 3'd1;
  localparam logic [2:0] ACT_DISPATCH = 3'd2;
  localparam logic [2:0] ACT_DELETE   = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;
  localparam logic [1:0] ST_NONE_DUE = 2'd3;

  // Most result words one dispatch may return.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_W       = 5;
  localparam logic [7:0]  RUNS_MAX    = 8'd255;

  // One stored task, without its link.
  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delta;
    logic [31:0] period;
    logic [31:0] ident;
    logic [7:0]  runs;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_WR,
    S_INS_RD,
    S_INS_CHK,
    S_INS_FIN,
    S_INS_LINK,
    S_DSP_RD,
    S_DSP_CHK,
    S_SUCC_RD,
    S_SUCC_WR,
    S_DEL_RD,
    S_DEL_CHK
  } state_t;

endpackage

// ===== rtl/dqs_mem.sv =====
module dqs_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int SW    = 5
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [IW-1:0]  rd_addr,
  output dqs_pkg::entry_t rd_entry,
  output logic [SW-1:0]  rd_link,
  input  logic           ent_we,
  input  logic [IW-1:0]  ent_addr,
  input  dqs_pkg::entry_t ent_wdata,
  input  logic           lnk_we,
  input  logic [IW-1:0]  lnk_addr,
  input  logic [SW-1:0]  lnk_wdata
);
  import dqs_pkg::*;

  entry_t      ent_mem [DEPTH];
  logic [SW-1:0] lnk_mem [DEPTH];

  // Task record memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (rd_en) begin
      rd_entry <= ent_mem[rd_addr];
    end
  end

  // Link memory, read at the same address as the records.
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_addr] <= lnk_wdata;
    end
    if (rd_en) begin
      rd_link <= lnk_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/delta_queue_task_scheduler_core.sv =====
// A tick reads and rewrites the head entry before its result word; clear and other status-only
// words answer from the decode state. Add and delete walk the list one entry at a time.
// A dispatch reads each due task, folds its delta into any successor and walks each periodic re-insert.
// Throughput: one word at a time; busy stays high until the last result word is issued.
// Result words are strobed for one cycle each and the receiver cannot stall them.
// Synchronous reset empties the list and sets the next id to 1; the memories are not cleared.
module delta_queue_task_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [7:0]  task_handle,
  input  logic [31:0] start_delay,
  input  logic [31:0] repeat_period,
  input  logic [31:0] target_id,
  output logic        strobe,
  output logic [1:0]  status,
  output logic        run_valid,
  output logic [7:0]  run_handle,
  output logic [31:0] issued_id,
  output logic        last_result
);
  import dqs_pkg::*;

  localparam int SW = $clog2(MAX_TASKS + 1);
  localparam int IW = $clog2(MAX_TASKS);
  localparam logic [SW-1:0] NIL = SW'(MAX_TASKS);

  state_t state, state_next;

  // Control and list registers.
  logic [MAX_TASKS-1:0] valid, valid_next;
  logic [SW-1:0]  head, head_next;
  logic [31:0]    next_ident, next_ident_next;
  logic [SW-1:0]  cur, cur_next, prev, prev_next, guard, guard_next;
  logic [RES_W-1:0] n_runs, n_runs_next;
  logic           pend_v, pend_v_next;
  logic           ins_ret, ins_ret_next;
  logic           succ_ret, succ_ret_next;

  // Payload registers.
  logic [2:0]     a_act;
  logic [7:0]     a_handle;
  logic [31:0]    a_delay, a_period, a_target;
  logic [31:0]    dval, dval_next;
  logic [IW-1:0]  ins_slot, ins_slot_next;
  logic [7:0]     ins_handle, ins_handle_next;
  logic [31:0]    ins_period, ins_period_next;
  logic [31:0]    ins_id, ins_id_next;
  logic [7:0]     pend_handle, pend_handle_next;
  logic [31:0]    pend_id, pend_id_next;
  logic [SW-1:0]  succ_slot, succ_slot_next;
  logic [31:0]    succ_add, succ_add_next;

  // Result register inputs.
  logic           strobe_next, run_valid_next, last_next;
  logic [1:0]     status_next;
  logic [7:0]     run_handle_next;
  logic [31:0]    issued_id_next;

  // Memory port.
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  entry_t         rd_entry;
  logic [SW-1:0]  rd_link;
  logic           ent_we, lnk_we;
  logic [IW-1:0]  ent_addr, lnk_addr;
  entry_t         ent_wdata;
  logic [SW-1:0]  lnk_wdata;

  // Helpers.
  logic           free_found;
  logic [IW-1:0]  free_idx;
  logic           head_ok, cur_ok, prev_ok, link_ok, walk_ok, res_room;
  logic [SW-1:0]  link_clip;
  logic [31:0]    tick_delta;
  logic [32:0]    succ_sum;

  dqs_mem #(.DEPTH(MAX_TASKS), .IW(IW), .SW(SW)) u_mem (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_entry(rd_entry), .rd_link(rd_link),
    .ent_we(ent_we), .ent_addr(ent_addr), .ent_wdata(ent_wdata),
    .lnk_we(lnk_we), .lnk_addr(lnk_addr), .lnk_wdata(lnk_wdata)
  );

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign head_ok    = head < NIL;
  assign cur_ok     = cur < NIL;
  assign prev_ok    = prev < NIL;
  assign link_ok    = rd_link < NIL;
  assign link_clip  = link_ok ? rd_link : NIL;
  assign walk_ok    = cur_ok && (guard < NIL);
  assign res_room   = n_runs < RES_W'(MAX_RESULTS);
  assign tick_delta = (rd_entry.delta != 32'd0) ? rd_entry.delta - 32'd1 : 32'd0;
  assign succ_sum   = {1'b0, rd_entry.delta} + {1'b0, succ_add};
  assign busy       = state != S_IDLE;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_DECODE;
      S_DECODE: begin
        case (a_act)
          ACT_TICK:     state_next = head_ok ? S_TICK_RD : S_IDLE;
          ACT_ADD:      state_next = free_found ? S_INS_RD : S_IDLE;
          ACT_DISPATCH: state_next = S_DSP_RD;
          ACT_DELETE:   state_next = S_DEL_RD;
          default:      state_next = S_IDLE;
        endcase
      end
      S_TICK_RD: state_next = S_TICK_WR;
      S_TICK_WR: state_next = S_IDLE;
      S_INS_RD:  state_next = walk_ok ? S_INS_CHK : S_INS_FIN;
      S_INS_CHK: state_next = (dval >= rd_entry.delta) ? S_INS_RD : S_INS_FIN;
      S_INS_FIN: state_next = S_INS_LINK;
      S_INS_LINK: state_next = ins_ret ? S_DSP_RD : S_IDLE;
      S_DSP_RD:  state_next = (res_room && head_ok) ? S_DSP_CHK : S_IDLE;
      S_DSP_CHK: begin
        if (rd_entry.runs == 8'd0) begin
          state_next = S_IDLE;
        end else if (link_ok) begin
          state_next = S_SUCC_RD;
        end else begin
          state_next = (rd_entry.period != 32'd0) ? S_INS_RD : S_DSP_RD;
        end
      end
      S_SUCC_RD: state_next = S_SUCC_WR;
      S_SUCC_WR: begin
        if (!succ_ret) begin
          state_next = S_IDLE;
        end else begin
          state_next = (ins_period != 32'd0) ? S_INS_RD : S_DSP_RD;
        end
      end
      S_DEL_RD:  state_next = walk_ok ? S_DEL_CHK : S_IDLE;
      S_DEL_CHK: begin
        if (rd_entry.ident == a_target) begin
          state_next = link_ok ? S_SUCC_RD : S_IDLE;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result words.
  always_comb begin
    valid_next       = valid;
    head_next        = head;
    next_ident_next  = next_ident;
    cur_next         = cur;
    prev_next        = prev;
    guard_next       = guard;
    n_runs_next      = n_runs;
    pend_v_next      = pend_v;
    ins_ret_next     = ins_ret;
    succ_ret_next    = succ_ret;
    dval_next        = dval;
    ins_slot_next    = ins_slot;
    ins_handle_next  = ins_handle;
    ins_period_next  = ins_period;
    ins_id_next      = ins_id;
    pend_handle_next = pend_handle;
    pend_id_next     = pend_id;
    succ_slot_next   = succ_slot;
    succ_add_next    = succ_add;
    strobe_next      = 1'b0;
    status_next      = ST_OK;
    run_valid_next   = 1'b0;
    run_handle_next  = '0;
    issued_id_next   = '0;
    last_next        = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = cur[IW-1:0];
    ent_we           = 1'b0;
    ent_addr         = cur[IW-1:0];
    ent_wdata        = rd_entry;
    lnk_we           = 1'b0;
    lnk_addr         = prev[IW-1:0];
    lnk_wdata        = cur;
    case (state)
      S_DECODE: begin
        case (a_act)
          ACT_TICK: begin
            if (!head_ok) begin
              strobe_next = 1'b1;
              last_next   = 1'b1;
            end
          end
          ACT_ADD: begin
            if (!free_found) begin
              strobe_next = 1'b1;
              status_next = ST_FULL;
              last_next   = 1'b1;
            end else begin
              ins_slot_next   = free_idx;
              ins_handle_next = a_handle;
              ins_period_next = a_period;
              dval_next       = a_delay;
              ins_id_next     = next_ident;
              next_ident_next = next_ident + 32'd1;
              cur_next        = head;
              prev_next       = NIL;
              guard_next      = '0;
              ins_ret_next    = 1'b0;
            end
          end
          ACT_DISPATCH: begin
            n_runs_next = '0;
            pend_v_next = 1'b0;
          end
          ACT_DELETE: begin
            cur_next   = head;
            prev_next  = NIL;
            guard_next = '0;
          end
          ACT_CLEAR: begin
            valid_next      = '0;
            head_next       = NIL;
            next_ident_next = 32'd1;
            strobe_next     = 1'b1;
            last_next       = 1'b1;
          end
          default: begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
          end
        endcase
      end
      S_TICK_RD: begin
        rd_en   = 1'b1;
        rd_addr = head[IW-1:0];
      end
      S_TICK_WR: begin
        ent_we          = 1'b1;
        ent_addr        = head[IW-1:0];
        ent_wdata.delta = tick_delta;
        if (tick_delta == 32'd0 && rd_entry.runs < RUNS_MAX) begin
          ent_wdata.runs = rd_entry.runs + 8'd1;
        end
        strobe_next = 1'b1;
        last_next   = 1'b1;
      end
      // Walk the list until the remaining delay falls below an entry's delta.
      S_INS_RD: begin
        rd_en = walk_ok;
      end
      S_INS_CHK: begin
        if (dval >= rd_entry.delta) begin
          dval_next  = dval - rd_entry.delta;
          prev_next  = cur;
          cur_next   = rd_link;
          guard_next = guard + SW'(1);
        end else begin
          ent_we          = 1'b1;
          ent_wdata.delta = rd_entry.delta - dval;
        end
      end
      S_INS_FIN: begin
        ent_we           = 1'b1;
        ent_addr         = ins_slot;
        ent_wdata.handle = ins_handle;
        ent_wdata.delta  = dval;
        ent_wdata.period = ins_period;
        ent_wdata.ident  = ins_id;
        ent_wdata.runs   = (dval == 32'd0) ? 8'd1 : 8'd0;
        lnk_we           = 1'b1;
        lnk_addr         = ins_slot;
        lnk_wdata        = cur_ok ? cur : NIL;
        valid_next[ins_slot] = 1'b1;
      end
      S_INS_LINK: begin
        if (prev_ok) begin
          lnk_we    = 1'b1;
          lnk_wdata = SW'(ins_slot);
        end else begin
          head_next = SW'(ins_slot);
        end
        if (ins_ret) begin
          pend_id_next = ins_id;
        end else begin
          strobe_next    = 1'b1;
          issued_id_next = ins_id;
          last_next      = 1'b1;
        end
      end
      // Dispatch: the previous task's word waits until the next head is known.
      S_DSP_RD: begin
        if (res_room && head_ok) begin
          rd_en   = 1'b1;
          rd_addr = head[IW-1:0];
        end else begin
          strobe_next     = 1'b1;
          last_next       = 1'b1;
          status_next     = pend_v ? ST_OK : ST_NONE_DUE;
          run_valid_next  = pend_v;
          run_handle_next = pend_v ? pend_handle : 8'd0;
          issued_id_next  = pend_v ? pend_id : 32'd0;
        end
      end
      S_DSP_CHK: begin
        strobe_next     = pend_v;
        run_valid_next  = pend_v;
        run_handle_next = pend_v ? pend_handle : 8'd0;
        issued_id_next  = pend_v ? pend_id : 32'd0;
        if (rd_entry.runs == 8'd0) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          status_next = pend_v ? ST_OK : ST_NONE_DUE;
        end else begin
          pend_v_next      = 1'b1;
          pend_handle_next = rd_entry.handle;
          pend_id_next     = '0;
          n_runs_next      = n_runs + RES_W'(1);
          valid_next[head[IW-1:0]] = 1'b0;
          head_next        = link_clip;
          ins_slot_next    = head[IW-1:0];
          ins_handle_next  = rd_entry.handle;
          ins_period_next  = rd_entry.period;
          dval_next        = rd_entry.period;
          succ_slot_next   = link_clip;
          succ_add_next    = rd_entry.delta;
          succ_ret_next    = 1'b1;
          ins_ret_next     = 1'b1;
          ins_id_next      = next_ident;
          cur_next         = link_clip;
          prev_next        = NIL;
          guard_next       = '0;
          if (!link_ok && rd_entry.period != 32'd0) begin
            next_ident_next = next_ident + 32'd1;
          end
        end
      end
      S_SUCC_RD: begin
        rd_en   = 1'b1;
        rd_addr = succ_slot[IW-1:0];
      end
      // Fold a removed entry's delta into its successor, saturating.
      S_SUCC_WR: begin
        ent_we          = 1'b1;
        ent_addr        = succ_slot[IW-1:0];
        ent_wdata.delta = succ_sum[32] ? 32'hFFFF_FFFF : succ_sum[31:0];
        if (!succ_ret) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
        end else if (ins_period != 32'd0) begin
          ins_id_next     = next_ident;
          next_ident_next = next_ident + 32'd1;
          cur_next        = head;
        end
      end
      S_DEL_RD: begin
        rd_en = walk_ok;
        if (!walk_ok) begin
          strobe_next = 1'b1;
          status_next = ST_NOT_FND;
          last_next   = 1'b1;
        end
      end
      S_DEL_CHK: begin
        if (rd_entry.ident == a_target) begin
          if (prev_ok) begin
            lnk_we    = 1'b1;
            lnk_wdata = link_clip;
          end else begin
            head_next = link_clip;
          end
          valid_next[cur[IW-1:0]] = 1'b0;
          succ_slot_next = link_clip;
          succ_add_next  = rd_entry.delta;
          succ_ret_next  = 1'b0;
          if (!link_ok) begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
          end
        end else begin
          prev_next  = cur;
          cur_next   = rd_link;
          guard_next = guard + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      head       <= NIL;
      next_ident <= 32'd1;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      valid      <= valid_next;
      head       <= head_next;
      next_ident <= next_ident_next;
      strobe     <= strobe_next;
    end
  end

  // Walk registers and payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      a_act    <= action;
      a_handle <= task_handle;
      a_delay  <= start_delay;
      a_period <= repeat_period;
      a_target <= target_id;
    end
    cur         <= cur_next;
    prev        <= prev_next;
    guard       <= guard_next;
    n_runs      <= n_runs_next;
    pend_v      <= pend_v_next;
    ins_ret     <= ins_ret_next;
    succ_ret    <= succ_ret_next;
    dval        <= dval_next;
    ins_slot    <= ins_slot_next;
    ins_handle  <= ins_handle_next;
    ins_period  <= ins_period_next;
    ins_id      <= ins_id_next;
    pend_handle <= pend_handle_next;
    pend_id     <= pend_id_next;
    succ_slot   <= succ_slot_next;
    succ_add    <= succ_add_next;
    status      <= status_next;
    run_valid   <= run_valid_next;
    run_handle  <= run_handle_next;
    issued_id   <= issued_id_next;
    last_result <= last_next;
  end

`ifndef NO_ASSERTIONS
  a_head_range: assert property (@(posedge clk) disable iff (rst) head <= NIL)
    else $error("head slot out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (strobe && status == ST_OK))
    else $error("run word without ok status");
  a_full_real: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == ST_FULL) |-> (&valid))
    else $error("table full reported with a free slot");
`endif

endmodule

// ===== bench/tb_delta_queue_task_scheduler_core.sv =====
module tb_delta_queue_task_scheduler_core;
  import dqs_pkg::*;

  localparam int SLOTS = 16;
  localparam int NO_SLOT = SLOTS;
  localparam int STALL_LIMIT = 5000;

  // One expected result word.
  typedef struct {
    logic [1:0]  status;
    logic        run_valid;
    logic [7:0]  run_handle;
    logic [31:0] issued_id;
    logic        last_result;
  } sched_word_t;

  // Scoreboard: keeps its own delta list and the results it still awaits.
  class sched_scoreboard;
    bit          used[SLOTS];
    bit [7:0]    hnd[SLOTS];
    bit [31:0]   dlt[SLOTS];
    bit [31:0]   per[SLOTS];
    bit [31:0]   ident[SLOTS];
    bit [7:0]    runs[SLOTS];
    int          link[SLOTS];
    int          head;
    bit [31:0]   next_id;
    sched_word_t awaited[$];
    int          errors;
    int          words;
    int          results;
    int          runs_seen;

    function new();
      foreach (used[i]) used[i] = 0;
      head = NO_SLOT;
      next_id = 1;
      errors = 0;
      words = 0;
      results = 0;
      runs_seen = 0;
    endfunction

    function void push(logic [1:0] st, logic rv, logic [7:0] rh, logic [31:0] id,
                       logic lst);
      sched_word_t w;
      w.status = st;
      w.run_valid = rv;
      w.run_handle = rh;
      w.issued_id = id;
      w.last_result = lst;
      awaited.push_back(w);
    endfunction

    // Places a slot in the list by absolute delay and hands out the next id.
    function bit [31:0] place(int s, bit [7:0] h, bit [31:0] d, bit [31:0] p);
      int prev;
      int cur;
      int g;
      bit [31:0] rem;
      bit [31:0] id;
      prev = NO_SLOT;
      cur = head;
      g = 0;
      rem = d;
      id = next_id;
      next_id = next_id + 1;
      while (cur != NO_SLOT && g < SLOTS && rem >= dlt[cur]) begin
        rem -= dlt[cur];
        prev = cur;
        cur = link[cur];
        g++;
      end
      if (cur != NO_SLOT) dlt[cur] -= rem;
      used[s] = 1;
      hnd[s] = h;
      dlt[s] = rem;
      per[s] = p;
      ident[s] = id;
      runs[s] = (rem == 0) ? 8'd1 : 8'd0;
      link[s] = cur;
      if (prev != NO_SLOT) link[prev] = s;
      else head = s;
      return id;
    endfunction

    // Folds a removed entry's delay into its successor, saturating.
    function void fold(int succ, bit [31:0] d);
      bit [32:0] sum;
      if (succ == NO_SLOT) return;
      sum = {1'b0, dlt[succ]} + {1'b0, d};
      dlt[succ] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Notes one accepted input word and predicts its results.
    function void note_word(logic [2:0] act, logic [7:0] h, logic [31:0] d,
                            logic [31:0] p, logic [31:0] tgt);
      int f;
      int n;
      int cur;
      int prev;
      int g;
      int nx;
      bit [31:0] nid;
      bit [7:0] hh;
      bit [31:0] pp;
      bit hit;
      words++;
      case (act)
        ACT_TICK: begin
          if (head != NO_SLOT) begin
            if (dlt[head] > 0) dlt[head]--;
            if (dlt[head] == 0 && runs[head] < RUNS_MAX) runs[head]++;
          end
          push(ST_OK, 0, 0, 0, 1);
        end
        ACT_ADD: begin
          f = -1;
          for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) f = i;
          if (f < 0) push(ST_FULL, 0, 0, 0, 1);
          else push(ST_OK, 0, 0, place(f, h, d, p), 1);
        end
        ACT_DISPATCH: begin
          n = 0;
          while (n < MAX_RESULTS && head != NO_SLOT && runs[head] > 0) begin
            f = head;
            hh = hnd[f];
            pp = per[f];
            nid = 0;
            head = link[f];
            fold(head, dlt[f]);
            used[f] = 0;
            if (pp > 0) nid = place(f, hh, pp, pp);
            push(ST_OK, 1, hh, nid, 0);
            n++;
          end
          if (n == 0) push(ST_NONE_DUE, 0, 0, 0, 1);
          else awaited[awaited.size() - 1].last_result = 1;
          runs_seen += n;
        end
        ACT_DELETE: begin
          prev = NO_SLOT;
          cur = head;
          g = 0;
          hit = 0;
          while (!hit && cur != NO_SLOT && g < SLOTS) begin
            if (ident[cur] == tgt) begin
              nx = link[cur];
              if (prev != NO_SLOT) link[prev] = nx;
              else head = nx;
              fold(nx, dlt[cur]);
              used[cur] = 0;
              hit = 1;
            end else begin
              prev = cur;
              cur = link[cur];
              g++;
            end
          end
          push(hit ? ST_OK : ST_NOT_FND, 0, 0, 0, 1);
        end
        ACT_CLEAR: begin
          foreach (used[i]) used[i] = 0;
          head = NO_SLOT;
          next_id = 1;
          push(ST_OK, 0, 0, 0, 1);
        end
        default: push(ST_OK, 0, 0, 0, 1);
      endcase
    endfunction

    // Compares one result word with the oldest prediction.
    function void check_result(logic [1:0] st, logic rv, logic [7:0] rh, logic [31:0] id,
                               logic lst);
      sched_word_t e;
      results++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word status=%0d run_valid=%0d handle=%0d id=%0d",
                 $time, st, rv, rh, id);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (rv !== e.run_valid) begin
        $display("%0t: run_valid expected %0d actual %0d", $time, e.run_valid, rv);
        errors++;
      end
      if (rh !== e.run_handle) begin
        $display("%0t: run_handle expected %0d actual %0d", $time, e.run_handle, rh);
        errors++;
      end
      if (id !== e.issued_id) begin
        $display("%0t: issued_id expected %0d actual %0d", $time, e.issued_id, id);
        errors++;
      end
      if (lst !== e.last_result) begin
        $display("%0t: last_result expected %0d actual %0d", $time, e.last_result, lst);
        errors++;
      end
    endfunction

    // Picks the id of a live task, or a random one when none is live.
    function bit [31:0] live_id();
      bit [31:0] ids[$];
      foreach (used[i]) if (used[i]) ids.push_back(ident[i]);
      if (ids.size() == 0) return $urandom();
      return ids[$urandom_range(ids.size() - 1)];
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [7:0]  task_handle;
  logic [31:0] start_delay;
  logic [31:0] repeat_period;
  logic [31:0] target_id;
  logic        strobe;
  logic [1:0]  status;
  logic        run_valid;
  logic [7:0]  run_handle;
  logic [31:0] issued_id;
  logic        last_result;

  sched_scoreboard sb;
  int idle_pct;
  int stall_cycles;

  delta_queue_task_scheduler_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .task_handle(task_handle), .start_delay(start_delay), .repeat_period(repeat_period),
    .target_id(target_id), .strobe(strobe), .status(status), .run_valid(run_valid),
    .run_handle(run_handle), .issued_id(issued_id), .last_result(last_result)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // Sends one word, with an optional random gap first, and waits for acceptance.
  task automatic send_word(logic [2:0] act, logic [7:0] h, logic [31:0] d, logic [31:0] p,
                           logic [31:0] tgt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    action <= act;
    task_handle <= h;
    start_delay <= d;
    repeat_period <= p;
    target_id <= tgt;
    do @(posedge clk); while (busy);
    sb.note_word(act, h, d, p, tgt);
  endtask

  // Mostly small delays so that tasks come due, with the odd full-range value.
  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(0, 5);
    if (r < 90) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 6);
    if (r < 95) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic random_word();
    int r;
    r = $urandom_range(99);
    if (r < 30) send_word(ACT_ADD, 8'($urandom()), pick_delay(), pick_period(), $urandom());
    else if (r < 58) send_word(ACT_TICK, 8'($urandom()), $urandom(), $urandom(), $urandom());
    else if (r < 78) begin
      send_word(ACT_DISPATCH, 8'($urandom()), $urandom(), $urandom(), $urandom());
    end
    else if (r < 88) send_word(ACT_DELETE, 8'($urandom()), $urandom(), $urandom(), sb.live_id());
    else if (r < 92) send_word(ACT_DELETE, 8'($urandom()), $urandom(), $urandom(), $urandom());
    else if (r < 95) send_word(ACT_CLEAR, 8'($urandom()), $urandom(), $urandom(), $urandom());
    else send_word(3'($urandom_range(5, 7)), 8'($urandom()), $urandom(), $urandom(), $urandom());
  endtask

  // Result words cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(status, run_valid, run_handle, issued_id, last_result);
  end

  // Watchdog on cycles in which neither an input nor a result word moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sb = new();
    idle_pct = 19;
    rst = 1;
    start = 0;
    action = ACT_TICK;
    task_handle = 0;
    start_delay = 0;
    repeat_period = 0;
    target_id = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: empty list cases, extremes, due tasks, delete, unused codes.
    send_word(ACT_TICK, 8'hFF, 0, 0, 0);
    send_word(ACT_DISPATCH, 0, 0, 0, 0);
    send_word(ACT_DELETE, 0, 0, 0, 32'd1);
    send_word(ACT_ADD, 8'h00, 0, 0, 0);
    send_word(ACT_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(ACT_ADD, 8'hA5, 32'd2, 32'd3, 0);
    send_word(ACT_ADD, 8'h5A, 32'd0, 32'd1, 0);
    send_word(ACT_DISPATCH, 0, 0, 0, 0);
    send_word(ACT_TICK, 0, 0, 0, 0);
    send_word(ACT_TICK, 0, 0, 0, 0);
    send_word(ACT_DISPATCH, 0, 0, 0, 0);
    send_word(ACT_DELETE, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(ACT_DELETE, 0, 0, 0, 32'd2);
    send_word(ACT_DELETE, 0, 0, 0, sb.live_id());
    send_word(3'd5, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(3'd6, 0, 0, 0, 0);
    send_word(3'd7, 0, 0, 0, 0);
    send_word(ACT_CLEAR, 0, 0, 0, 0);
    // Fill the table past full, then run a dispatch with every task due.
    for (int i = 0; i < SLOTS + 1; i++) send_word(ACT_ADD, 8'(i), 0, 32'(i % 2), 0);
    send_word(ACT_DISPATCH, 0, 0, 0, 0);
    send_word(ACT_CLEAR, 0, 0, 0, 0);

    // Random part in three idling phases.
    for (int i = 0; i < 320; i++) begin
      if (i == 107) idle_pct = 45;
      if (i == 214) idle_pct = 0;
      random_word();
    end
    start <= 0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Run covered %0d input words, %0d result words, %0d task runs.",
             sb.words, sb.results, sb.runs_seen);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d results still awaited", sb.errors, sb.awaited.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dqs_pkg.sv
rtl/dqs_mem.sv
rtl/delta_queue_task_scheduler_core.sv
bench/tb_delta_queue_task_scheduler_core.sv
